// ===== rtl/nsms_pkg.sv =====
// ============================================================================
// nsms_pkg
// Shared widths, constants and types of the next-smaller-element stack block.
// ============================================================================
`default_nettype none

package nsms_pkg;

   // Width of one array element and of one result.
   localparam int VALUE_W  = 30;
   localparam int RESULT_W = 31;

   // Default number of stack entries.
   localparam int STACK_DEPTH_DEF = 1024;

   // Result code reported when no smaller element exists (-1, all ones).
   localparam logic signed [RESULT_W-1:0] NONE_CODE = {RESULT_W{1'b1}};

   // Sequencer states of the stack controller.
   typedef enum logic [0:0] {
      NSMS_IDLE,
      NSMS_BUSY
   } nsms_state_type;

endpackage

`default_nettype wire

// ===== rtl/nsms_if.sv =====
// ============================================================================
// nsms_if
// Valid/ready channel interfaces for the request and response streams.
// ============================================================================
`default_nettype none

interface nsms_req_if;
   logic                             valid;
   logic                             ready;
   logic [nsms_pkg::VALUE_W-1:0]     value;
   logic                             first;

   modport source (output valid, output value, output first, input ready);
   modport sink   (input valid, input value, input first, output ready);
endinterface

interface nsms_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [nsms_pkg::RESULT_W-1:0] next_smaller;
   logic                                overflow;

   modport source (output valid, output next_smaller, output overflow, input ready);
   modport sink   (input valid, input next_smaller, input overflow, output ready);
endinterface

`default_nettype wire

// ===== rtl/nsms_stack_ram.sv =====
// ============================================================================
// nsms_stack_ram
// Simple dual-port stack memory: one write port, one registered read port.
// ============================================================================
`default_nettype none

module nsms_stack_ram #(
   parameter int DEPTH = nsms_pkg::STACK_DEPTH_DEF,
   parameter int WIDTH = nsms_pkg::VALUE_W,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read data holds until the next read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/next_smaller_monotonic_stack.sv =====
// ============================================================================
// next_smaller_monotonic_stack
// Next strictly smaller element to the right, using a monotonic stack.
// ============================================================================
// Array elements are transferred in reverse order, rightmost first; an element
// with first set empties the stack before it is processed. Each element pops
// every stacked value greater than or equal to itself, reports the new top of
// the stack (or -1 when the stack is empty) and is then pushed. When the stack
// already holds STACK_DEPTH entries the deepest one is discarded and overflow
// is set on that result. Each pop moves the entry below up to the top and
// reads the entry under that one through the single read port of the stack
// memory, and the cycle that pushes the element also loads the result
// register. Every element is pushed exactly once. The top two stack entries
// are held in registers, so an element that pops nothing is finished in the
// cycle of its transfer if the output register is free. A new element is
// accepted whenever the block is idle, even while a result still waits in
// the output register; it then stalls only when it must hand over its own
// result. The stack memory is a circular buffer with a base pointer, so
// discarding the deepest entry costs no copying and the memory needs no
// clearing after reset.
// ============================================================================
`default_nettype none

module next_smaller_monotonic_stack #(
   parameter int STACK_DEPTH = nsms_pkg::STACK_DEPTH_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   nsms_req_if.sink   req_ch,
   nsms_rsp_if.source rsp_ch
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int SW = AW + 1;
   localparam int VW = nsms_pkg::VALUE_W;

   // Physical address of a logical stack position, position 0 being the deepest.
   function automatic logic [AW-1:0] phys_addr(input logic [AW-1:0] base,
                                                input logic [CW-1:0] pos);
      logic [SW-1:0] sum;
      sum = SW'(base) + SW'(pos);
      if (sum >= SW'(STACK_DEPTH)) begin
         sum = sum - SW'(STACK_DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   // ------------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------------
   nsms_pkg::nsms_state_type state_ff, state_in;
   logic [VW-1:0]            value_ff, value_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [AW-1:0]            base_ff, base_in;
   // Cached copies of the entry on top and the one just below it.
   logic [VW-1:0]            top_ff, top_in;
   logic [VW-1:0]            below_ff, below_in;
   // Set while the entry below the top is the memory read data, not below_ff.
   logic                     below_mem_ff, below_mem_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [nsms_pkg::RESULT_W-1:0] rsp_next_ff, rsp_next_in;
   logic                     rsp_ovf_ff, rsp_ovf_in;

   // Memory port signals.
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [VW-1:0] rd_data;

   // Working values of the element in hand.
   logic          req_transfer;
   logic          active;
   logic          out_free;
   logic [VW-1:0] cur_value;
   logic [CW-1:0] cur_count;
   logic [VW-1:0] cur_below;
   logic          pop_need;
   logic          do_pop;
   logic          do_push;

   nsms_stack_ram #(
      .DEPTH (STACK_DEPTH),
      .WIDTH (VW),
      .AW    (AW)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (cur_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ch.ready = (state_ff == nsms_pkg::NSMS_IDLE);
   assign req_transfer = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign active       = req_transfer || (state_ff == nsms_pkg::NSMS_BUSY);

   // In the transfer cycle the element comes straight from the port, and a set
   // first flag empties the stack before anything is compared.
   always_comb begin
      if (state_ff == nsms_pkg::NSMS_IDLE) begin
         cur_value = req_ch.value;
         cur_count = req_ch.first ? '0 : count_ff;
      end else begin
         cur_value = value_ff;
         cur_count = count_ff;
      end
      cur_below = below_mem_ff ? rd_data : below_ff;
   end

   assign pop_need = (cur_count != '0) && (top_ff >= cur_value);
   assign do_pop   = active && pop_need;
   assign do_push  = active && !pop_need && out_free;

   // ------------------------------------------------------------------------
   // Sequencer: next state and datapath control
   // ------------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      value_in     = req_transfer ? req_ch.value : value_ff;
      count_in     = count_ff;
      base_in      = base_ff;
      top_in       = top_ff;
      below_in     = below_ff;
      below_mem_in = below_mem_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_next_in  = rsp_next_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      wr_en        = 1'b0;
      wr_addr      = phys_addr(base_ff, cur_count);
      rd_en        = 1'b0;
      rd_addr      = phys_addr(base_ff, (cur_count >= CW'(3)) ? cur_count - CW'(3) : '0);

      if (do_pop) begin
         // The entry below moves up to the top, and the one under it is read
         // so that it is ready in the next cycle.
         count_in     = cur_count - CW'(1);
         top_in       = cur_below;
         below_mem_in = 1'b1;
         rd_en        = 1'b1;
         state_in     = nsms_pkg::NSMS_BUSY;
      end else if (do_push) begin
         rsp_valid_in = 1'b1;
         rsp_next_in  = (cur_count == '0) ? nsms_pkg::NONE_CODE
                                          : $signed({1'b0, top_ff});
         wr_en        = 1'b1;
         if (cur_count == CW'(STACK_DEPTH)) begin
            // Full stack: the new value takes the slot of the deepest entry and
            // the base pointer moves past it.
            wr_addr    = base_ff;
            base_in    = (base_ff == AW'(STACK_DEPTH - 1)) ? '0 : base_ff + AW'(1);
            count_in   = cur_count;
            rsp_ovf_in = 1'b1;
         end else begin
            count_in   = cur_count + CW'(1);
            rsp_ovf_in = 1'b0;
         end
         below_in     = top_ff;
         top_in       = cur_value;
         below_mem_in = 1'b0;
         state_in     = nsms_pkg::NSMS_IDLE;
      end else if (active) begin
         // Result ready but the output register is still occupied.
         count_in = cur_count;
         state_in = nsms_pkg::NSMS_BUSY;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nsms_pkg::NSMS_IDLE;
         count_ff     <= '0;
         base_ff      <= '0;
         below_mem_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         base_ff      <= base_in;
         below_mem_ff <= below_mem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff    <= value_in;
      top_ff      <= top_in;
      below_ff    <= below_in;
      rsp_next_ff <= rsp_next_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.next_smaller = rsp_next_ff;
   assign rsp_ch.overflow     = rsp_ovf_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   // The fill count never goes beyond the stack depth.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(STACK_DEPTH))
      else $error("stack count beyond depth");

   // An overflow only happens on a full stack, so its result is never -1.
   a_ovf_not_none: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ovf_ff) |-> (rsp_next_ff != nsms_pkg::NONE_CODE))
      else $error("overflow reported together with an empty stack");

   // A first element with a free output register reports -1 in the next cycle.
   a_first_none: assert property (@(posedge clock) disable iff (reset)
      (req_transfer && req_ch.first && out_free) |=>
         (rsp_valid_ff && rsp_next_ff == nsms_pkg::NONE_CODE && !rsp_ovf_ff))
      else $error("first element did not report -1");

   // Each pop removes exactly one entry.
   a_pop_step: assert property (@(posedge clock) disable iff (reset)
      do_pop |=> (count_ff == $past(cur_count) - CW'(1)))
      else $error("pop did not remove one entry");

   // The base pointer only moves on a push onto a full stack.
   a_base_move: assert property (@(posedge clock) disable iff (reset)
      (base_ff != base_in) |-> (do_push && cur_count == CW'(STACK_DEPTH)))
      else $error("base pointer moved without an overflow");

endmodule

`default_nettype wire
